FILE: src/sdt_pkg.sv
// Shared types, codes and defaults for the seen-device table.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sdt_pkg;

  localparam int unsigned SDT_TABLE_ENTRIES = 256;
  localparam int unsigned SDT_SLOT_W        = 8;
  localparam int unsigned SDT_COUNT_W       = 9;
  localparam int unsigned SDT_CFG_IDX_W     = 1;
  localparam int unsigned SDT_CFG_DATA_W    = 2;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [SDT_CFG_IDX_W-1:0] CFG_IGNORE_RANDOM_NAMELESS = 1'd0;
  localparam logic [SDT_CFG_IDX_W-1:0] CFG_BLE_DOMAIN_CODE        = 1'd1;

  localparam logic [1:0] BLE_DOMAIN_RESET = 2'd1;

  typedef enum logic [2:0] {
    STS_UPDATED  = 3'd0,
    STS_APPENDED = 3'd1,
    STS_EVICTED  = 3'd2,
    STS_FILTERED = 3'd3,
    STS_HIT      = 3'd4,
    STS_MISS     = 3'd5,
    STS_CLEARED  = 3'd6
  } sdt_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } sdt_state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  domain;
    logic [47:0] mac_addr;
    logic        addr_random;
    logic        name_empty;
    logic [31:0] time_ms;
  } sdt_in_t;

  typedef struct packed {
    sdt_status_e            status;
    logic [SDT_SLOT_W-1:0]  slot;
    logic [31:0]            first_seen;
    logic [31:0]            last_seen;
    logic [SDT_COUNT_W-1:0] entry_count;
    logic [31:0]            filtered_total;
  } sdt_out_t;

  typedef struct packed {
    logic [1:0]  domain;
    logic [47:0] mac;
    logic [31:0] first;
    logic [31:0] last;
  } sdt_entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic emit;
  } sdt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sdt_sts_t;

endpackage

`default_nettype wire

FILE: src/sdt_ctrl.sv
// Sequencer for the seen-device table: accept, scan, commit, respond.
// Depends on sdt_pkg; drives the datapath through sdt_cmd_t.
`default_nettype none

module sdt_ctrl
  import sdt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  sdt_sts_t   sts_i,
  output sdt_cmd_t   cmd_o
);

  sdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_DECIDE: cmd_o.commit = 1'b1;
      S_RESP:   cmd_o.emit   = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/sdt_datapath.sv
// Entry memory, key and oldest-time scan, outcome logic and result register.
// Depends on sdt_pkg; sequenced by sdt_ctrl.
`default_nettype none

module sdt_datapath
  import sdt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = SDT_TABLE_ENTRIES
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [SDT_CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [SDT_CFG_DATA_W-1:0]   cfg_wdata_i,
  input  sdt_in_t                    in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output sdt_out_t                   out_data_o,
  input  sdt_cmd_t                   cmd_i,
  output sdt_sts_t                   sts_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_ENTRIES);

  sdt_entry_t mem [TABLE_ENTRIES];

  logic                ignore_q;
  logic [1:0]          ble_dom_q;
  sdt_in_t             item_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [31:0]         drop_q, drop_d;
  logic [CNT_W-1:0]    addr_q;
  logic                rd_pend_q;
  logic [IDX_W-1:0]    rd_idx_q;
  sdt_entry_t          rd_q;
  logic                hit_q;
  logic [IDX_W-1:0]    hit_idx_q;
  logic [31:0]         hit_first_q, hit_last_q;
  logic [IDX_W-1:0]    min_idx_q;
  logic [31:0]         min_last_q;
  sdt_out_t            res_q, res_d;
  logic                out_valid_q;
  sdt_out_t            out_q;

  logic                is_clear;
  logic                issue;
  logic                key_eq;
  logic                wr_en;
  logic [IDX_W-1:0]    sel_idx;
  sdt_entry_t          wr_entry;
  logic                show;
  logic [SDT_SLOT_W+IDX_W-1:0]    slot_w;
  logic [SDT_COUNT_W+CNT_W-1:0]   cnt_w;

  assign is_clear = (item_q.func == FUNC_CLEAR);
  assign issue    = cmd_i.scan && !is_clear && (addr_q < count_q);
  assign key_eq   = (rd_q.domain == item_q.domain) && (rd_q.mac == item_q.mac_addr);

  assign sts_o.scan_done = !issue && !rd_pend_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ignore_q  <= 1'b0;
      ble_dom_q <= BLE_DOMAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IGNORE_RANDOM_NAMELESS: ignore_q  <= cfg_wdata_i[0];
        CFG_BLE_DOMAIN_CODE:        ble_dom_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    rd_q     <= mem[addr_q[IDX_W-1:0]];
    rd_idx_q <= addr_q[IDX_W-1:0];
    if (cmd_i.commit && wr_en) mem[sel_idx] <= wr_entry;
    if (cmd_i.commit) res_q <= res_d;
    if (cmd_i.emit) out_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_q      <= '0;
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_first_q <= '0;
      hit_last_q  <= '0;
      min_idx_q   <= '0;
      min_last_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_pend_q <= issue;
      if (cmd_i.load) begin
        addr_q <= '0;
        hit_q  <= 1'b0;
      end else if (issue) begin
        addr_q <= addr_q + 1'b1;
      end
      if (rd_pend_q) begin
        if (!hit_q && key_eq) begin
          hit_q       <= 1'b1;
          hit_idx_q   <= rd_idx_q;
          hit_first_q <= rd_q.first;
          hit_last_q  <= rd_q.last;
        end
        if (rd_idx_q == '0 || rd_q.last < min_last_q) begin
          min_idx_q  <= rd_idx_q;
          min_last_q <= rd_q.last;
        end
      end
      if (cmd_i.commit) begin
        count_q <= count_d;
        drop_q  <= drop_d;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr_en                = 1'b0;
    sel_idx              = hit_idx_q;
    wr_entry.domain      = item_q.domain;
    wr_entry.mac         = item_q.mac_addr;
    wr_entry.first       = item_q.time_ms;
    wr_entry.last        = item_q.time_ms;
    show                 = 1'b0;
    count_d              = count_q;
    drop_d               = drop_q;
    res_d.status         = STS_MISS;
    res_d.first_seen     = '0;
    res_d.last_seen      = '0;
    if (is_clear) begin
      res_d.status = STS_CLEARED;
      count_d      = '0;
    end else if (item_q.func != FUNC_UPDATE) begin
      if (hit_q) begin
        res_d.status     = STS_HIT;
        show             = 1'b1;
        res_d.first_seen = hit_first_q;
        res_d.last_seen  = hit_last_q;
      end
    end else if (hit_q) begin
      res_d.status     = STS_UPDATED;
      wr_en            = 1'b1;
      wr_entry.first   = hit_first_q;
      show             = 1'b1;
      res_d.first_seen = hit_first_q;
      res_d.last_seen  = item_q.time_ms;
    end else if (ignore_q && item_q.domain == ble_dom_q && item_q.addr_random &&
                 item_q.name_empty) begin
      res_d.status = STS_FILTERED;
      drop_d       = drop_q + 32'd1;
    end else if (count_q < FULL) begin
      res_d.status     = STS_APPENDED;
      sel_idx          = count_q[IDX_W-1:0];
      wr_en            = 1'b1;
      count_d          = count_q + 1'b1;
      show             = 1'b1;
      res_d.first_seen = item_q.time_ms;
      res_d.last_seen  = item_q.time_ms;
    end else begin
      res_d.status     = STS_EVICTED;
      sel_idx          = min_idx_q;
      wr_en            = 1'b1;
      show             = 1'b1;
      res_d.first_seen = item_q.time_ms;
      res_d.last_seen  = item_q.time_ms;
    end
    slot_w               = {{SDT_SLOT_W{1'b0}}, sel_idx};
    cnt_w                = {{SDT_COUNT_W{1'b0}}, count_d};
    res_d.slot           = show ? slot_w[SDT_SLOT_W-1:0] : '0;
    res_d.entry_count    = cnt_w[SDT_COUNT_W-1:0];
    res_d.filtered_total = drop_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/seen_device_table_lru_evict.sv
// Top level of the seen-device table with least-recently-seen replacement.
// Depends on sdt_pkg, sdt_ctrl and sdt_datapath.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    in_data_i   (sdt_in_t)
//   out      output     out_valid_o / out_stall_i  out_data_o  (sdt_out_t)
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One item at a time: the next beat is taken only once the last has responded; the
// single read port of the entry memory scans one valid entry a cycle for the key and
// the oldest last-seen time, and a clear or an empty table skips the scan.
// Reset empties the table, zeroes the filtered count and loads register defaults.
// A stalled output beat holds in its register; the next input beat is taken
// meanwhile and waits to respond until the output register frees up.
`default_nettype none

module seen_device_table_lru_evict
  import sdt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = SDT_TABLE_ENTRIES
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [SDT_CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [SDT_CFG_DATA_W-1:0]   cfg_wdata_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  sdt_in_t                    in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output sdt_out_t                   out_data_o
);

  sdt_cmd_t cmd;
  sdt_sts_t sts;

  sdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sdt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
